>>> sv/string_list_exchange_sort_assert.svh
// Assertion macros for the string list exchange sort top module.
// Depends on nothing; included by files that carry assertions.
`ifndef STRING_LIST_EXCHANGE_SORT_ASSERT_SVH
`define STRING_LIST_EXCHANGE_SORT_ASSERT_SVH

// implication checked on rising clock, off during reset
`define SLES_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SLES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/sles_pkg.sv
// Package for the string list exchange sort: state codes and shared types.
// No dependencies.
package sles_pkg;
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_LOAD  = 3'd0;
    localparam logic [STATE_W-1:0] ST_INIT  = 3'd1;
    localparam logic [STATE_W-1:0] ST_CMP   = 3'd2;
    localparam logic [STATE_W-1:0] ST_NEXT  = 3'd3;
    localparam logic [STATE_W-1:0] ST_EMIT  = 3'd4;
    localparam logic [STATE_W-1:0] ST_RDO   = 3'd5;

    localparam int SRC_W = 4;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
        logic greater;
    } cmp_ctrl_t;
endpackage

>>> sv/string_list_exchange_sort.sv
// Load: the end-of-list item starts the sort.
// Sort: n(n-1)/2 pairs, each compared byte by byte up to the first mismatch or the shorter length.
// Results then leave one per cycle while m_tready is high; no input is taken meanwhile.
// Reset (aresetn low, synchronous) clears counts, flags and sequencer; stores are not cleared.
// Throughput: one character per cycle during load.
module string_list_exchange_sort #(
    parameter int MAX_STRINGS = 16,
    parameter int MAX_CHARS   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,   // end_of_list
    input  logic        s_tuser,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] source_index, [4] overflowed, [7:5] zero
    output logic        m_tlast    // last_rank
);
    `include "string_list_exchange_sort_assert.svh"

    localparam int IDX_W = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
    localparam int CNT_W = $clog2(MAX_STRINGS + 1);
    localparam int POS_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int LEN_W = $clog2(MAX_CHARS + 1);

    logic [sles_pkg::STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [LEN_W-1:0] lens [MAX_STRINGS];
    logic [IDX_W-1:0] rank_reg [MAX_STRINGS];
    logic [IDX_W-1:0] ri, rj;
    logic out_v_reg, out_last_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic start;
    logic acc, eos, keep_str, keep_ch;
    sles_pkg::cmp_ctrl_t cc;

    assign acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == sles_pkg::ST_LOAD);
    assign eos = s_tuser || s_tlast;
    assign keep_str = cnt_reg < CNT_W'(MAX_STRINGS);
    assign keep_ch = keep_str && (pos_reg < LEN_W'(MAX_CHARS));
    assign ri = rank_reg[i_reg];
    assign rj = rank_reg[j_reg];
    assign start = (state_reg == sles_pkg::ST_INIT);

    function automatic logic [LEN_W-1:0] pos_next_len();
        return keep_ch ? LEN_W'(pos_reg + 1'b1) : pos_reg;
    endfunction

    sles_compare #(
        .MAX_STRINGS(MAX_STRINGS), .MAX_CHARS(MAX_CHARS),
        .IDX_W(IDX_W), .POS_W(POS_W), .LEN_W(LEN_W)
    ) u_cmp (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(acc && keep_ch), .wr_str(cnt_reg[IDX_W-1:0]),
        .wr_pos(pos_reg[POS_W-1:0]), .wr_data(s_tdata),
        .start(start), .str_a(ri), .str_b(rj),
        .len_a(lens[ri]), .len_b(lens[rj]), .ctrl(cc)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        i_next = i_reg;
        j_next = j_reg;
        case (state_reg)
            sles_pkg::ST_LOAD: begin
                if (acc) begin
                    if (keep_ch) pos_next = pos_reg + 1'b1;
                    else ovf_next = 1'b1;
                    if (eos) begin
                        pos_next = '0;
                        if (keep_str) cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = '0;
                        j_next = IDX_W'(1);
                        if (keep_str) begin
                            state_next = (cnt_reg == '0) ? sles_pkg::ST_EMIT
                                : sles_pkg::ST_INIT;
                        end else begin
                            state_next = (cnt_reg < CNT_W'(2)) ? sles_pkg::ST_EMIT
                                : sles_pkg::ST_INIT;
                        end
                    end
                end
            end
            sles_pkg::ST_INIT: state_next = sles_pkg::ST_CMP;
            sles_pkg::ST_CMP: if (cc.done) state_next = sles_pkg::ST_NEXT;
            sles_pkg::ST_NEXT: begin
                if (CNT_W'(j_reg) + 1'b1 < cnt_reg) begin
                    j_next = j_reg + 1'b1;
                    state_next = sles_pkg::ST_INIT;
                end else if (CNT_W'(i_reg) + 2'd2 < cnt_reg) begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + 2'd2;
                    state_next = sles_pkg::ST_INIT;
                end else begin
                    i_next = '0;
                    state_next = sles_pkg::ST_EMIT;
                end
            end
            sles_pkg::ST_EMIT: begin
                if (cnt_reg == '0) begin
                    state_next = sles_pkg::ST_LOAD;
                    ovf_next = 1'b0;
                end else if (!out_v_reg || m_tready) begin
                    if (CNT_W'(i_reg) + 1'b1 == cnt_reg) begin
                        state_next = sles_pkg::ST_RDO;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            sles_pkg::ST_RDO: begin
                if (!out_v_reg || m_tready) begin
                    state_next = sles_pkg::ST_LOAD;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    i_next = '0;
                end
            end
            default: state_next = sles_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sles_pkg::ST_LOAD;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == sles_pkg::ST_EMIT && cnt_reg == '0) ? '0 : cnt_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (state_reg == sles_pkg::ST_EMIT && cnt_reg != '0 && (!out_v_reg || m_tready))
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_tlast) begin
            for (int k = 0; k < MAX_STRINGS; k++) rank_reg[k] <= IDX_W'(k);
        end
        if (acc && eos && keep_str) begin
            lens[cnt_reg[IDX_W-1:0]] <= pos_next_len();
        end
        if (state_reg == sles_pkg::ST_CMP && cc.done && cc.greater) begin
            rank_reg[i_reg] <= rj;
            rank_reg[j_reg] <= ri;
        end
        if (state_reg == sles_pkg::ST_EMIT && cnt_reg != '0 && (!out_v_reg || m_tready)) begin
            out_idx_reg  <= ri;
            out_last_reg <= (CNT_W'(i_reg) + 1'b1 == cnt_reg);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, ovf_reg, sles_pkg::SRC_W'(out_idx_reg)};
    assign m_tlast  = out_last_reg;

    `SLES_ASSERT_IMP(a_no_in_busy, aclk, aresetn, state_reg != sles_pkg::ST_LOAD, !s_tready)
    `SLES_ASSERT_NEXT(a_cmp_start, aclk, aresetn, state_reg == sles_pkg::ST_INIT, cc.busy)
    `SLES_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_STRINGS))
endmodule

>>> sv/sles_compare.sv
// Byte-serial string comparator: compares one character pair at a time, read from two copies of the store.
// Uses sles_pkg; holds the character store itself.
module sles_compare #(
    parameter int MAX_STRINGS = 16,
    parameter int MAX_CHARS   = 128,
    parameter int IDX_W       = 4,
    parameter int POS_W       = 7,
    parameter int LEN_W       = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_str,
    input  logic [POS_W-1:0]     wr_pos,
    input  logic [7:0]           wr_data,
    input  logic                 start,
    input  logic [IDX_W-1:0]     str_a,
    input  logic [IDX_W-1:0]     str_b,
    input  logic [LEN_W-1:0]     len_a,
    input  logic [LEN_W-1:0]     len_b,
    output sles_pkg::cmp_ctrl_t  ctrl
);
    localparam int ADDR_W = IDX_W + POS_W;

    logic [7:0] mem_a [MAX_STRINGS*MAX_CHARS];
    logic [7:0] mem_b [MAX_STRINGS*MAX_CHARS];
    logic [7:0] rd_a_reg, rd_b_reg;
    logic [LEN_W-1:0] k_reg, k_next;
    logic busy_reg, busy_next, rdv_reg, rdv_next, done_reg, done_next;
    logic gt_reg, gt_next;
    logic [LEN_W-1:0] n;
    logic [ADDR_W-1:0] addr_a, addr_b, addr_w;

    assign n = (len_a < len_b) ? len_a : len_b;
    assign addr_a = ADDR_W'(str_a) * ADDR_W'(MAX_CHARS) + ADDR_W'(k_reg[POS_W-1:0]);
    assign addr_b = ADDR_W'(str_b) * ADDR_W'(MAX_CHARS) + ADDR_W'(k_reg[POS_W-1:0]);
    assign addr_w = ADDR_W'(wr_str) * ADDR_W'(MAX_CHARS) + ADDR_W'(wr_pos);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[addr_w] <= wr_data;
            mem_b[addr_w] <= wr_data;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    always_comb begin
        k_next = k_reg;
        busy_next = busy_reg;
        rdv_next = 1'b0;
        done_next = 1'b0;
        gt_next = gt_reg;
        if (start) begin
            k_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rdv_reg && rd_a_reg != rd_b_reg) begin
                gt_next = rd_a_reg > rd_b_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!rdv_reg && k_reg >= n) begin
                gt_next = len_a > len_b;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!rdv_reg) begin
                rdv_next = 1'b1;
            end else begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rdv_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
            gt_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            rdv_reg  <= rdv_next;
            done_reg <= done_next;
            k_reg    <= k_next;
            gt_reg   <= gt_next;
        end
    end

    assign ctrl.start   = start;
    assign ctrl.busy    = busy_reg;
    assign ctrl.done    = done_reg;
    assign ctrl.greater = gt_reg;
endmodule

>>> verif/tb_string_list_exchange_sort.sv
// Testbench for string_list_exchange_sort: loads string lists and checks the sorted rank order.
// Depends on the RTL top string_list_exchange_sort only; self-checking predictor inside.
`timescale 1ns / 1ps

module tb_string_list_exchange_sort;
    localparam int NSTR = 16;
    localparam int NCHR = 128;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       eol;
    } char_item_t;

    typedef struct packed {
        logic [3:0] src;
        logic       last;
        logic       ovf;
    } rank_t;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_tvalid = 0;
    logic       s_tready;
    logic [7:0] s_tdata = 0;
    logic       s_tlast = 0;
    logic       s_tuser = 0;
    logic       m_tvalid;
    logic       m_tready = 0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    string_list_exchange_sort dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    char_item_t pending_chars[$];
    rank_t      expected_ranks[$];
    int         errors = 0;
    int         lists_sent = 0;
    int         ranks_seen = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_recv = 0;
    longint     cycles = 0;

    // sorter model state
    logic [7:0] str_chars[NSTR][NCHR];
    logic [7:0] str_len[NSTR];
    int         n_strings = 0;
    int         n_chars = 0;
    bit         dropped = 0;

    initial forever #6 aclk = ~aclk;

    function automatic bit str_after(int a, int b);
        int n;
        n = str_len[a] < str_len[b] ? str_len[a] : str_len[b];
        for (int k = 0; k < n; k++)
            if (str_chars[a][k] != str_chars[b][k])
                return str_chars[a][k] > str_chars[b][k];
        return str_len[a] > str_len[b];
    endfunction

    task automatic absorb_char(char_item_t it);
        bit eos;
        int order[NSTR];
        int t;
        rank_t r;
        eos = it.eos | it.eol;
        if (n_strings < NSTR && n_chars < NCHR) begin
            str_chars[n_strings][n_chars] = it.ch;
            n_chars++;
        end else begin
            dropped = 1;
        end
        if (eos) begin
            if (n_strings < NSTR) begin
                str_len[n_strings] = 8'(n_chars);
                n_strings++;
            end
            n_chars = 0;
        end
        if (!it.eol) return;
        for (int i = 0; i < n_strings; i++) order[i] = i;
        for (int i = 0; i + 1 < n_strings; i++)
            for (int j = i + 1; j < n_strings; j++)
                if (str_after(order[i], order[j])) begin
                    t = order[i]; order[i] = order[j]; order[j] = t;
                end
        for (int k = 0; k < n_strings; k++) begin
            r.src = order[k][3:0];
            r.last = (k + 1 == n_strings);
            r.ovf = dropped;
            expected_ranks.push_back(r);
        end
        n_strings = 0;
        n_chars = 0;
        dropped = 0;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) absorb_char({s_tdata, s_tuser, s_tlast});
            if ((!s_tvalid || s_tready)) begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    char_item_t it;
                    it = pending_chars.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= it.ch;
                    s_tuser <= it.eos;
                    s_tlast <= it.eol;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rank_t e;
                ranks_seen++;
                if (expected_ranks.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_ranks.pop_front();
                    if (m_tdata[3:0] != e.src)
                        report_mismatch($sformatf("source_index %0d, want %0d",
                                                  m_tdata[3:0], e.src));
                    if (m_tdata[4] != e.ovf)
                        report_mismatch($sformatf("overflowed %0b, want %0b",
                                                  m_tdata[4], e.ovf));
                    if (m_tlast != e.last)
                        report_mismatch($sformatf("last_rank %0b, want %0b",
                                                  m_tlast, e.last));
                    if (m_tdata[7:5] != 3'b000) report_mismatch("padding bits nonzero");
                end
            end
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // one string; chars random nonzero, or from a small alphabet to force shared prefixes
    task automatic queue_string(int len, bit narrow, bit last);
        char_item_t it;
        for (int k = 0; k < len; k++) begin
            it.ch = narrow ? 8'($urandom_range(97, 99)) : 8'($urandom_range(1, 255));
            it.eos = (k == len - 1);
            it.eol = last && (k == len - 1);
            pending_chars.push_back(it);
        end
    endtask

    task automatic queue_list(int nstr, int maxlen);
        bit narrow;
        narrow = $urandom_range(1);
        for (int s = 0; s < nstr; s++)
            queue_string($urandom_range(1, maxlen), narrow, s == nstr - 1);
        lists_sent++;
    endtask

    task automatic push_char(logic [7:0] ch, bit eos, bit eol);
        char_item_t it;
        it.ch = ch; it.eos = eos; it.eol = eol;
        pending_chars.push_back(it);
    endtask

    task automatic drain();
        while (pending_chars.size() > 0 || s_tvalid || expected_ranks.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // directed: single string, extremes, prefix, eol without eos, zero byte
        push_char(8'hFF, 1, 1);
        push_char(8'd1, 0, 0); push_char(8'hFF, 1, 0);
        push_char(8'd1, 1, 0);
        push_char(8'h00, 1, 0);
        push_char(8'h80, 0, 0); push_char(8'h7F, 0, 1);
        lists_sent += 2;
        // equal strings
        push_char(8'h41, 0, 0); push_char(8'h42, 1, 0);
        push_char(8'h41, 0, 0); push_char(8'h42, 0, 1);
        // too many strings
        for (int s = 0; s < NSTR + 1; s++) push_char(8'($urandom_range(1, 255)), 1, s == NSTR);
        lists_sent += 2;
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 19 : 0;
            recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 19 : 0;
            for (int l = 0; l < 2; l++) queue_list($urandom_range(1, 5), 3);
            if (ph == 0) begin
                hold_recv = 1;
                queue_list(3, 2);
                repeat (400) @(posedge aclk);
                hold_recv = 0;
            end
            drain();
        end
        queue_list(NSTR, 1);
        drain();

        repeat (200) @(posedge aclk);
        $display("%0d lists loaded, %0d ranked results checked, %0d mismatches",
                 lists_sent, ranks_seen, errors);
        if (errors == 0 && expected_ranks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/sles_pkg.sv
sv/sles_compare.sv
sv/string_list_exchange_sort.sv
verif/tb_string_list_exchange_sort.sv
